/* src/ffha_pkg.sv */
`default_nettype none
package ffha_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_REALLOC = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_ALC_RD,
    S_ALC_WT,
    S_ALC_CHK,
    S_ALC_SPLIT,
    S_ALC_MARK,
    S_FND_RD,
    S_FND_WT,
    S_FND_CHK,
    S_RLC_CHK,
    S_REL_MARK,
    S_MRG_RD,
    S_MRG_WT,
    S_MRG_CHK,
    S_MRG_NRD,
    S_MRG_NWT,
    S_MRG_NCHK,
    S_MRG_WR,
    S_SUM_RD,
    S_SUM_WT,
    S_SUM_CHK,
    S_OUT
  } state_t;

  localparam int unsigned GRAN_SHIFT = 4;
  localparam int unsigned SPLIT_MIN  = 2;
  localparam int unsigned ENTRY_W    = 18;

endpackage
`default_nettype wire

/* src/ffha_ram.sv */
`default_nettype none
module ffha_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/first_fit_heap_allocator.sv */
`default_nettype none
// Channel | Dir | tdata (low bit up)                         | tuser
// in_     | in  | func[1:0], request_bytes[21:2], address[41:22] | -
// out_    | out | result_address[19:0], status[21:20],
//         |     | used_bytes[42:22], largest_free_bytes[63:43] | -
// One request at a time; in_tready is high only in idle.
// A request walks the block list once for each phase it needs (alloc, lookup, merge,
// totals), and the merge also reads the neighbor of each free block, besides decode,
// marks and the result; the single table read port paces every walk.
// Reset: no clearing pass; the root block (entry 0) is written during reset and on the
// first cycle after it, and in_tready stays low on that cycle.
// The result register holds while out_tready is low; no new request meanwhile.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_GRANULES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // func, request_bytes, address, zero fill
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [63:0] out_tdata   // result_address, status, used_bytes, largest_free_bytes
);
  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_GRANULES);
  localparam int unsigned SW = $clog2(HEAP_GRANULES + 1);
  localparam int unsigned CW = AW + 2;
  localparam logic [CW-1:0] HEAP_END = CW'(HEAP_GRANULES);

  state_t state_r, state_nxt;
  logic   init_r;

  logic [1:0]  func_r;
  logic [19:0] req_r, addr_r;
  logic [CW-1:0] g_r, g_nxt, n_r, old_r;
  logic [19:0] target_r;
  logic [19:0] g_ext;
  logic [SW-1:0] s_r, need_r, big_r, used_r;
  logic [SW-1:0] old_s_r;
  logic [19:0] res_r;
  logic [1:0]  status_r;
  logic        rel_after_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [SW-1:0] rd_size;
  logic          rd_free;

  ffha_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_GRANULES)) u_tab (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign rd_free = rdata[ENTRY_W-1];
  assign rd_size = rdata[SW-1:0];
  assign g_ext   = 20'(g_r);

  logic [CW-1:0] nx_blk;
  assign nx_blk = (rd_size == '0) ? HEAP_END : (g_r + CW'(rd_size));

  logic [20:0] need_c;
  assign need_c = (21'(in_tdata[21:2]) + 21'd31) >> GRAN_SHIFT;

  assign in_tready = (state_r == S_IDLE) && !init_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_DECODE;
      S_DECODE: begin
        if (func_r == FUNC_ALLOC || (func_r == FUNC_REALLOC && addr_r == '0))
          state_nxt = (req_r == '0) ? S_SUM_RD : S_ALC_RD;
        else if (func_r == FUNC_FREE)
          state_nxt = (addr_r == '0) ? S_SUM_RD : S_FND_RD;
        else if (func_r == FUNC_REALLOC) state_nxt = S_FND_RD;
        else state_nxt = S_SUM_RD;
      end
      S_ALC_RD:  state_nxt = (g_r >= HEAP_END) ? S_SUM_RD : S_ALC_WT;
      S_ALC_WT:  state_nxt = S_ALC_CHK;
      S_ALC_CHK: begin
        if (rd_free && rd_size >= need_r)
          state_nxt = (rd_size >= need_r + SW'(SPLIT_MIN) &&
                       g_r + CW'(need_r) < HEAP_END) ? S_ALC_SPLIT : S_ALC_MARK;
        else state_nxt = S_ALC_RD;
      end
      S_ALC_SPLIT: state_nxt = S_ALC_MARK;
      S_ALC_MARK:  state_nxt = rel_after_r ? S_REL_MARK : S_SUM_RD;
      S_FND_RD: begin
        if (g_r >= HEAP_END || g_ext > target_r || addr_r[3:0] != '0)
          state_nxt = S_SUM_RD;
        else state_nxt = S_FND_WT;
      end
      S_FND_WT:  state_nxt = S_FND_CHK;
      S_FND_CHK: begin
        if (g_ext == target_r)
          state_nxt = rd_free ? S_SUM_RD :
                      (func_r == FUNC_FREE || req_r == '0) ? S_REL_MARK : S_RLC_CHK;
        else state_nxt = S_FND_RD;
      end
      S_RLC_CHK: state_nxt = ((24'(s_r) - 24'd1) << GRAN_SHIFT >= 24'(req_r)) ?
                             S_SUM_RD : S_ALC_RD;
      S_REL_MARK: state_nxt = S_MRG_RD;
      S_MRG_RD:   state_nxt = (g_r >= HEAP_END) ? S_SUM_RD : S_MRG_WT;
      S_MRG_WT:   state_nxt = S_MRG_CHK;
      S_MRG_CHK: begin
        if (rd_free && nx_blk < HEAP_END) state_nxt = S_MRG_NRD;
        else state_nxt = S_MRG_RD;
      end
      S_MRG_NRD:  state_nxt = S_MRG_NWT;
      S_MRG_NWT:  state_nxt = S_MRG_NCHK;
      S_MRG_NCHK: state_nxt = rd_free ? S_MRG_WR : S_MRG_RD;
      S_MRG_WR: begin
        if (g_r + CW'(s_r) + CW'(rd_size) < HEAP_END && rd_size != '0)
          state_nxt = S_MRG_NRD;
        else state_nxt = S_MRG_RD;
      end
      S_SUM_RD:  state_nxt = (g_r >= HEAP_END) ? S_OUT : S_SUM_WT;
      S_SUM_WT:  state_nxt = S_SUM_CHK;
      S_SUM_CHK: state_nxt = S_SUM_RD;
      S_OUT:     if (out_tready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // table port control
  always_comb begin
    we    = 1'b0;
    waddr = g_r[AW-1:0];
    wdata = '0;
    raddr = g_r[AW-1:0];
    g_nxt = g_r;
    if (init_r) begin
      we    = 1'b1;
      waddr = '0;
      wdata = {1'b1, (ENTRY_W-1)'(HEAP_GRANULES)};
    end else begin
      unique case (state_r)
        S_ALC_SPLIT: begin
          we    = 1'b1;
          waddr = AW'(g_r + CW'(need_r));
          wdata = {1'b1, (ENTRY_W-1)'(s_r - need_r)};
        end
        S_ALC_MARK: begin
          we    = 1'b1;
          wdata = {1'b0, (ENTRY_W-1)'(
                   (s_r >= need_r + SW'(SPLIT_MIN) && g_r + CW'(need_r) < HEAP_END)
                   ? need_r : s_r)};
        end
        S_REL_MARK: begin
          we    = 1'b1;
          waddr = old_r[AW-1:0];
          wdata = {1'b1, (ENTRY_W-1)'(old_s_r)};
        end
        // hold the neighbor address until its entry has been sampled
        S_MRG_NRD, S_MRG_NWT, S_MRG_NCHK: raddr = n_r[AW-1:0];
        S_MRG_WR: begin
          we    = 1'b1;
          wdata = {1'b1, (ENTRY_W-1)'(s_r + rd_size)};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      init_r     <= 1'b1;
    end else begin
      state_r <= state_nxt;
      init_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (in_tvalid && in_tready) begin
        func_r      <= in_tdata[1:0];
        req_r       <= in_tdata[21:2];
        addr_r      <= in_tdata[41:22];
        need_r      <= (need_c > 21'(HEAP_GRANULES)) ? SW'(HEAP_GRANULES + 1) :
                       SW'(need_c);
        target_r    <= 20'(in_tdata[41:26]) - 20'd1;
        res_r       <= '0;
        status_r    <= ST_OK;
        rel_after_r <= 1'b0;
        g_r         <= '0;
      end
      S_DECODE: begin
        g_r   <= '0;
        old_r <= CW'(target_r);
        if (func_r == FUNC_FREE && addr_r != '0 && addr_r[3:0] != '0)
          status_r <= ST_BADADDR;
        if (func_r == FUNC_REALLOC && addr_r != '0 && addr_r[3:0] != '0)
          status_r <= ST_BADADDR;
      end
      // a failed realloc keeps the old block
      S_ALC_RD: if (g_r >= HEAP_END) begin
        status_r    <= ST_NOMEM;
        res_r       <= '0;
        g_r         <= '0;
        rel_after_r <= 1'b0;
      end
      S_ALC_CHK: begin
        s_r <= rd_size;
        if (!(rd_free && rd_size >= need_r)) g_r <= nx_blk;
        else res_r <= 20'((g_r + CW'(1)) << GRAN_SHIFT);
      end
      S_ALC_MARK: g_r <= '0;
      S_FND_RD: if (g_r >= HEAP_END || g_ext > target_r || addr_r[3:0] != '0) begin
        status_r <= ST_BADADDR;
        g_r      <= '0;
      end
      S_FND_CHK: begin
        s_r <= rd_size;
        if (g_ext == target_r) begin
          if (rd_free) status_r <= ST_BADADDR;
          g_r <= '0;
        end else g_r <= nx_blk;
      end
      S_RLC_CHK: begin
        if ((24'(s_r) - 24'd1) << GRAN_SHIFT >= 24'(req_r)) res_r <= addr_r;
        else rel_after_r <= 1'b1;
        g_r <= '0;
      end
      S_REL_MARK: g_r <= '0;
      S_MRG_RD: if (g_r >= HEAP_END) g_r <= '0;
      S_MRG_CHK: begin
        s_r <= rd_size;
        n_r <= nx_blk;
        if (!(rd_free && nx_blk < HEAP_END)) g_r <= nx_blk;
      end
      S_MRG_NCHK: if (!rd_free) g_r <= n_r;
      S_MRG_WR: begin
        s_r <= s_r + rd_size;
        n_r <= n_r + CW'(rd_size);
      end
      S_SUM_RD: if (g_r >= HEAP_END) ; else if (g_r == '0) begin
        used_r <= '0;
        big_r  <= '0;
      end
      S_SUM_CHK: begin
        if (rd_free) begin
          if (rd_size > big_r) big_r <= rd_size;
        end else used_r <= used_r + rd_size;
        g_r <= nx_blk;
      end
      default: ;
    endcase
  end

  // old block size for the release is kept apart from the walk
  always_ff @(posedge clk) begin
    if (state_r == S_FND_CHK && g_ext == target_r) old_s_r <= rd_size;
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {21'(32'(big_r) << GRAN_SHIFT), 21'(32'(used_r) << GRAN_SHIFT),
                       status_r, res_r};

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE)) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("result moved");
  a_no_null_ok_nomem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && status_r == ST_NOMEM) |-> (res_r == '0)) else $error("nomem addr");
endmodule
`default_nettype wire

/* test/tb_first_fit_heap_allocator.sv */
`default_nettype none
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int unsigned HEAP_G = 4096;
  localparam int unsigned CYCLE_LIMIT = 6000000;

  typedef struct packed {
    func_t       func;
    logic [19:0] req_bytes;
    logic [19:0] addr;
  } alloc_req_t;

  typedef struct packed {
    logic [19:0] res_addr;
    status_t     status;
    logic [20:0] used;
    logic [20:0] largest;
  } alloc_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // func, request_bytes, address, zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // result_address, status, used_bytes, largest_free_bytes

  first_fit_heap_allocator #(.HEAP_GRANULES(HEAP_G)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // heap shadow
  int unsigned blk_size [HEAP_G];
  bit          blk_free [HEAP_G];
  logic [19:0] live_addrs [$];

  alloc_req_t  pending_reqs [$];
  alloc_rsp_t  expected_rsps [$];
  int          mismatches;
  int unsigned cycle_count;
  bit          hold_off;
  bit          calm;

  function automatic int unsigned next_blk(int unsigned g);
    if (blk_size[g] == 0) return HEAP_G;
    return g + blk_size[g];
  endfunction

  function automatic void merge_free();
    int unsigned g, n;
    g = 0;
    while (g < HEAP_G) begin
      while (blk_free[g]) begin
        n = next_blk(g);
        if (n >= HEAP_G || !blk_free[n]) break;
        blk_size[g] += blk_size[n];
      end
      g = next_blk(g);
    end
  endfunction

  function automatic int unsigned first_fit(int unsigned req);
    int unsigned need, g, s;
    need = (req + 31) / 16;
    g = 0;
    while (g < HEAP_G) begin
      s = blk_size[g];
      if (blk_free[g] && s >= need) begin
        if (s >= need + SPLIT_MIN && g + need < HEAP_G) begin
          blk_size[g + need] = s - need;
          blk_free[g + need] = 1;
          blk_size[g] = need;
        end
        blk_free[g] = 0;
        return (g + 1) * 16;
      end
      g = next_blk(g);
    end
    return 0;
  endfunction

  function automatic int find_block(int unsigned addr);
    int unsigned target, g;
    if (addr == 0 || addr % 16 != 0) return -1;
    target = addr / 16 - 1;
    g = 0;
    while (g < HEAP_G) begin
      if (g == target) return blk_free[g] ? -1 : int'(g);
      if (g > target) return -1;
      g = next_blk(g);
    end
    return -1;
  endfunction

  function automatic void drop_live(logic [19:0] a);
    foreach (live_addrs[i])
      if (live_addrs[i] == a) begin
        live_addrs.delete(i);
        return;
      end
  endfunction

  function automatic alloc_rsp_t heap_step(alloc_req_t r);
    alloc_rsp_t  o;
    int          b;
    int unsigned g, used, big, res;
    res = 0;
    o.status = ST_OK;
    if (r.func == FUNC_ALLOC || (r.func == FUNC_REALLOC && r.addr == 0)) begin
      if (r.req_bytes != 0) begin
        res = first_fit(r.req_bytes);
        if (res == 0) o.status = ST_NOMEM;
        else live_addrs.push_back(20'(res));
      end
    end else if (r.func == FUNC_FREE) begin
      if (r.addr != 0) begin
        b = find_block(r.addr);
        if (b < 0) o.status = ST_BADADDR;
        else begin
          blk_free[b] = 1;
          merge_free();
          drop_live(r.addr);
        end
      end
    end else if (r.func == FUNC_REALLOC) begin
      b = find_block(r.addr);
      if (b < 0) o.status = ST_BADADDR;
      else if (r.req_bytes == 0) begin
        blk_free[b] = 1;
        merge_free();
        drop_live(r.addr);
      end else if ((blk_size[b] - 1) * 16 >= r.req_bytes) res = r.addr;
      else begin
        res = first_fit(r.req_bytes);
        if (res == 0) o.status = ST_NOMEM;
        else begin
          blk_free[b] = 1;
          merge_free();
          drop_live(r.addr);
          live_addrs.push_back(20'(res));
        end
      end
    end
    used = 0;
    big = 0;
    g = 0;
    while (g < HEAP_G) begin
      if (blk_free[g]) begin
        if (blk_size[g] > big) big = blk_size[g];
      end else used += blk_size[g];
      g = next_blk(g);
    end
    o.res_addr = res[19:0];
    o.used = 21'(used * 16);
    o.largest = 21'(big * 16);
    return o;
  endfunction

  function automatic logic [19:0] pick_addr();
    if (live_addrs.size() == 0 || $urandom_range(9) == 0) return 20'($urandom);
    return live_addrs[$urandom_range(live_addrs.size() - 1)];
  endfunction

  // mostly modest sizes, now and then huge ones
  function automatic logic [19:0] pick_size();
    case ($urandom_range(9))
      0:       return 20'($urandom);
      1:       return 20'($urandom_range(16384));
      default: return 20'($urandom_range(1, 600));
    endcase
  endfunction

  task automatic add_req(func_t f, logic [19:0] sz, logic [19:0] a);
    alloc_req_t r;
    r.func = f;
    r.req_bytes = sz;
    r.addr = a;
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // driver: the model state advances on each accepted request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_rsps.push_back(heap_step(pending_reqs.pop_front()));
      end
      if (in_tvalid && !in_tready) begin
        // hold the request
      end else if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 14)) begin
        in_tvalid <= 1;
        in_tdata <= {6'b0, pending_reqs[0].addr, pending_reqs[0].req_bytes,
                     pending_reqs[0].func};
      end else in_tvalid <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    alloc_rsp_t got, want;
    if (!rst_n) out_tready <= 0;
    else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[19:0], out_tdata[21:20], out_tdata[42:22], out_tdata[63:43]};
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %h", out_tdata);
        end else begin
          want = expected_rsps.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp addr %0d st %0d used %0d big %0d, got %0d %0d %0d %0d",
                       want.res_addr, want.status, want.used, want.largest,
                       got.res_addr, got.status, got.used, got.largest);
          end
        end
      end
      out_tready <= !hold_off && (calm || $urandom_range(99) >= 14);
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    hold_off = 0;
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    int n;
    calm = 0;
    mismatches = 0;
    blk_size[0] = HEAP_G;
    blk_free[0] = 1;
    // extremes and special cases
    add_req(FUNC_ALLOC, 20'd0, 20'd0);
    add_req(FUNC_ALLOC, 20'hFFFFF, 20'hFFFFF);
    add_req(FUNC_ALLOC, 20'd1, 20'd0);
    add_req(FUNC_ALLOC, 20'd16, 20'd0);
    add_req(FUNC_ALLOC, 20'd17, 20'd0);
    add_req(FUNC_FREE, 20'd0, 20'd0);
    add_req(FUNC_FREE, 20'd0, 20'd24);
    add_req(FUNC_FREE, 20'd0, 20'd16);
    add_req(FUNC_FREE, 20'd0, 20'd16);
    add_req(FUNC_REALLOC, 20'd40, 20'd0);
    add_req(FUNC_REALLOC, 20'd8, 20'd48);
    add_req(FUNC_REALLOC, 20'd400, 20'd48);
    add_req(FUNC_REALLOC, 20'd65520, 20'd16);
    add_req(FUNC_REALLOC, 20'd70000, 20'd16);
    add_req(FUNC_REALLOC, 20'd0, 20'd32);
    add_req(FUNC_REALLOC, 20'd10, 20'd32);
    add_req(FUNC_NONE, 20'hFFFFF, 20'hFFFFF);
    add_req(FUNC_ALLOC, 20'd65504, 20'd0);
    add_req(FUNC_ALLOC, 20'd65520, 20'd0);
    add_req(FUNC_FREE, 20'hAAAAA, 20'h55550);
    for (n = 0; n < 120; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: add_req(FUNC_ALLOC, pick_size(), 20'($urandom));
        4, 5, 6:    add_req(FUNC_FREE, 20'($urandom), pick_addr());
        7, 8:       add_req(FUNC_REALLOC, $urandom_range(4) == 0 ? 20'd0 : pick_size(),
                            pick_addr());
        default:    add_req(func_t'($urandom_range(3)), 20'($urandom), 20'($urandom));
      endcase
    end
    // no idling on either side for a stretch of about forty requests
    wait (pending_reqs.size() <= 90);
    calm = 1;
    wait (pending_reqs.size() <= 50);
    calm = 0;
    wait (pending_reqs.size() == 0 && !in_tvalid && expected_rsps.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
